@@ hw/rtl/papc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the parallel activity pair counter.
package papc_pkg;

   // Fixed field widths of the request and response transfers.
   localparam int ACT_W        = 6;
   localparam int CASE_W       = 32;
   localparam int LC_W         = 2;
   localparam int PAIR_COUNT_W = 32;

   localparam logic [PAIR_COUNT_W-1:0] PAIR_COUNT_MAX = '1;

   // Default sizes handed to the top level parameters.
   localparam int DEF_NUM_ACTIVITIES = 64;
   localparam int DEF_COUNT_WIDTH    = 32;
   localparam int DEF_OPEN_WIDTH     = 8;

   // Command queue between front and back end; depth must be a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Request codes.
   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [LC_W-1:0] LC_START    = 2'd0;
   localparam logic [LC_W-1:0] LC_COMPLETE = 2'd1;

   // Work for the back end after classification.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_START,
      OP_COMPLETE,
      OP_READ
   } papc_op_type;

   typedef struct packed {
      papc_op_type      op;
      logic             new_case;
      logic             read_zero;
      logic [ACT_W-1:0] act;
      logic [ACT_W-1:0] oth;
   } papc_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } papc_qstat_type;

endpackage

@@ hw/rtl/papc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts requests, tracks the current case and classifies commands.
module papc_front #(
   parameter int NUM_ACTIVITIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [papc_pkg::CASE_W-1:0]       req_case_id,
   input  logic [papc_pkg::ACT_W-1:0]        req_activity,
   input  logic [papc_pkg::LC_W-1:0]         req_lifecycle,
   input  logic [papc_pkg::ACT_W-1:0]        req_other_activity,
   input  papc_pkg::papc_qstat_type          q_stat,
   input  logic                              init_done,
   output logic                              push,
   output papc_pkg::papc_cmd_type            push_cmd
);
   import papc_pkg::*;

   localparam int IDX_W = $clog2(NUM_ACTIVITIES);
   localparam int CMP_W = (IDX_W + 1 > ACT_W) ? IDX_W + 1 : ACT_W;

   logic [CASE_W-1:0] current_case_ff, current_case_in;
   logic              case_seen_ff, case_seen_in;
   logic              act_ok;
   logic              oth_ok;
   logic              is_new_case;

   assign act_ok = CMP_W'(req_activity) < CMP_W'(NUM_ACTIVITIES);
   assign oth_ok = CMP_W'(req_other_activity) < CMP_W'(NUM_ACTIVITIES);
   assign is_new_case = !case_seen_ff || (req_case_id != current_case_ff);

   assign req_ready = init_done && !q_stat.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_cmd.act       = req_activity;
      push_cmd.oth       = req_other_activity;
      push_cmd.new_case  = 1'b0;
      push_cmd.read_zero = 1'b0;
      push_cmd.op        = OP_NONE;
      current_case_in    = current_case_ff;
      case_seen_in       = case_seen_ff;
      if (req_command == CMD_READ) begin
         push_cmd.op        = OP_READ;
         push_cmd.read_zero = !(act_ok && oth_ok);
      end else begin
         push_cmd.new_case = is_new_case;
         if (act_ok && req_lifecycle == LC_START) begin
            push_cmd.op = OP_START;
         end else if (act_ok && req_lifecycle == LC_COMPLETE) begin
            push_cmd.op = OP_COMPLETE;
         end
         if (push) begin
            current_case_in = req_case_id;
            case_seen_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_case_ff <= '0;
         case_seen_ff    <= 1'b0;
      end else begin
         current_case_ff <= current_case_in;
         case_seen_ff    <= case_seen_in;
      end
   end

endmodule

@@ hw/rtl/papc_queue.sv @@
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module papc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  papc_pkg::papc_cmd_type   push_cmd,
   input  logic                     pop,
   output papc_pkg::papc_cmd_type   q_data,
   output papc_pkg::papc_qstat_type q_stat
);
   import papc_pkg::*;

   papc_cmd_type             queue_slots [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;

   assign q_data       = queue_slots[rd_ptr_ff];
   assign q_stat.full  = count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign q_stat.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_slots[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_ff == count_in ? count_ff : count_in;
      end
   end

endmodule

@@ hw/rtl/papc_back.sv @@
`timescale 1ns / 1ps
// Back end: open-count store, pair-count memory, start sweep and read path.
module papc_back #(
   parameter int NUM_ACTIVITIES = 64,
   parameter int COUNT_WIDTH    = 32,
   parameter int OPEN_WIDTH     = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  papc_pkg::papc_qstat_type          q_stat,
   input  papc_pkg::papc_cmd_type            q_data,
   output logic                              q_pop,
   output logic                              init_done,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [papc_pkg::PAIR_COUNT_W-1:0] rsp_pair_count
);
   import papc_pkg::*;

   localparam int IDX_W     = $clog2(NUM_ACTIVITIES);
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int SCAN_W    = IDX_W + 1;
   localparam int ADD_W     = ((COUNT_WIDTH > OPEN_WIDTH + 1) ? COUNT_WIDTH : OPEN_WIDTH + 1) + 1;
   localparam int RD_W      = (COUNT_WIDTH > PAIR_COUNT_W) ? COUNT_WIDTH : PAIR_COUNT_W;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
   localparam logic [OPEN_WIDTH-1:0]  OPEN_MAX = '1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_WR1,
      S_WR2,
      S_OWRITE,
      S_RDOUT
   } state_type;

   // Storage.
   logic [COUNT_WIDTH-1:0] pair_mem [MEM_DEPTH];
   logic [OPEN_WIDTH-1:0]  open_mem [NUM_ACTIVITIES];

   // Control and payload registers.
   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       clr_addr_ff, clr_addr_in;
   logic [SCAN_W-1:0]       a_ff, a_in;
   logic [IDX_W-1:0]        b_ff, b_in;
   logic                    zero_ff, zero_in;
   logic [NUM_ACTIVITIES-1:0] open_valid_ff, open_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PAIR_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Memory ports.
   logic                    pm_we;
   logic [ADDR_W-1:0]       pm_waddr;
   logic [COUNT_WIDTH-1:0]  pm_wdata;
   logic                    pm_re;
   logic [ADDR_W-1:0]       pm_raddr_a;
   logic [ADDR_W-1:0]       pm_raddr_b;
   logic [COUNT_WIDTH-1:0]  pm_rdata_a_ff;
   logic [COUNT_WIDTH-1:0]  pm_rdata_b_ff;
   logic                    om_we;
   logic [IDX_W-1:0]        om_waddr;
   logic [OPEN_WIDTH-1:0]   om_wdata;
   logic                    om_re;
   logic [IDX_W-1:0]        om_raddr;
   logic [OPEN_WIDTH-1:0]   om_rdata_ff;

   // Datapath.
   logic [IDX_W-1:0]        a_idx;
   logic [IDX_W-1:0]        cmd_act_idx;
   logic [IDX_W-1:0]        cmd_oth_idx;
   logic                    scan_done;
   logic                    same_slot;
   logic                    rsp_free;
   logic [ADD_W-1:0]        m_ext;
   logic [ADD_W-1:0]        add1_v;
   logic [ADD_W-1:0]        sum1;
   logic [ADD_W-1:0]        sum2;
   logic [COUNT_WIDTH-1:0]  sat1;
   logic [COUNT_WIDTH-1:0]  sat2;
   logic [OPEN_WIDTH-1:0]   open_inc;
   logic [RD_W-1:0]         rd_ext;
   logic [PAIR_COUNT_W-1:0] rd_sat;

   assign a_idx       = a_ff[IDX_W-1:0];
   assign cmd_act_idx = IDX_W'(q_data.act);
   assign cmd_oth_idx = IDX_W'(q_data.oth);
   assign scan_done   = a_ff == SCAN_W'(NUM_ACTIVITIES);
   assign same_slot   = a_idx == b_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   assign q_pop = (state_ff == S_IDLE) && !q_stat.empty &&
                  ((q_data.op != OP_READ) || rsp_free);
   assign init_done      = state_ff != S_CLEAR;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_count = rsp_count_ff;

   // Saturating updates of the pair counts.
   assign m_ext  = ADD_W'(om_rdata_ff);
   assign add1_v = same_slot ? (m_ext << 1) : m_ext;
   assign sum1   = ADD_W'(pm_rdata_a_ff) + add1_v;
   assign sum2   = ADD_W'(pm_rdata_b_ff) + m_ext;
   assign sat1   = (sum1 > ADD_W'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(sum1);
   assign sat2   = (sum2 > ADD_W'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(sum2);

   assign open_inc = (om_rdata_ff == OPEN_MAX) ? om_rdata_ff : om_rdata_ff + OPEN_WIDTH'(1);

   assign rd_ext = RD_W'(pm_rdata_a_ff);
   assign rd_sat = (rd_ext > RD_W'(PAIR_COUNT_MAX)) ? PAIR_COUNT_MAX : PAIR_COUNT_W'(rd_ext);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      zero_in       = zero_ff;
      open_valid_in = open_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_count_in  = rsp_count_ff;
      pm_we         = 1'b0;
      pm_waddr      = {a_idx, b_ff};
      pm_wdata      = sat1;
      pm_re         = 1'b0;
      pm_raddr_a    = {a_idx, b_ff};
      pm_raddr_b    = {b_ff, a_idx};
      om_we         = 1'b0;
      om_waddr      = b_ff;
      om_wdata      = open_inc;
      om_re         = 1'b0;
      om_raddr      = a_idx;

      unique case (state_ff)
         S_CLEAR: begin
            pm_we       = 1'b1;
            pm_waddr    = clr_addr_ff;
            pm_wdata    = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_pop) begin
               if (q_data.new_case) begin
                  open_valid_in = '0;
               end
               unique case (q_data.op)
                  OP_NONE: begin
                  end
                  OP_COMPLETE: begin
                     open_valid_in[cmd_act_idx] = 1'b0;
                  end
                  OP_START: begin
                     b_in     = cmd_act_idx;
                     a_in     = '0;
                     state_in = S_SCAN;
                  end
                  OP_READ: begin
                     pm_re      = 1'b1;
                     pm_raddr_a = {cmd_act_idx, cmd_oth_idx};
                     zero_in    = q_data.read_zero;
                     state_in   = S_RDOUT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               om_re    = 1'b1;
               om_raddr = b_ff;
               state_in = S_OWRITE;
            end else if (open_valid_ff[a_idx]) begin
               pm_re    = 1'b1;
               om_re    = 1'b1;
               state_in = S_WR1;
            end else begin
               a_in = a_ff + SCAN_W'(1);
            end
         end
         S_WR1: begin
            pm_we = 1'b1;
            if (same_slot) begin
               a_in     = a_ff + SCAN_W'(1);
               state_in = S_SCAN;
            end else begin
               state_in = S_WR2;
            end
         end
         S_WR2: begin
            pm_we    = 1'b1;
            pm_waddr = {b_ff, a_idx};
            pm_wdata = sat2;
            a_in     = a_ff + SCAN_W'(1);
            state_in = S_SCAN;
         end
         S_OWRITE: begin
            om_we                = 1'b1;
            om_wdata             = open_valid_ff[b_ff] ? open_inc : OPEN_WIDTH'(1);
            open_valid_in[b_ff]  = 1'b1;
            state_in             = S_IDLE;
         end
         S_RDOUT: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = zero_ff ? '0 : rd_sat;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         a_ff          <= '0;
         open_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         a_ff          <= a_in;
         open_valid_ff <= open_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      b_ff         <= b_in;
      zero_ff      <= zero_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (pm_we) begin
         pair_mem[pm_waddr] <= pm_wdata;
      end
      if (pm_re) begin
         pm_rdata_a_ff <= pair_mem[pm_raddr_a];
         pm_rdata_b_ff <= pair_mem[pm_raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (om_we) begin
         open_mem[om_waddr] <= om_wdata;
      end
      if (om_re) begin
         om_rdata_ff <= open_mem[om_raddr];
      end
   end

endmodule

@@ hw/rtl/parallel_activity_pair_counter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the parallel activity pair counter.
//
// The unit takes event-log lifecycle transfers and pair-count reads on the
// req_ channel and returns one rsp_ transfer for each read, in request order.
// A start of activity b adds, for every activity a with open instances in the
// current case, the open multiplicity of a to the counts of pairs (a,b) and
// (b,a), twice to (b,b), and then opens one more instance of b. A complete
// closes all open instances of its activity, and a new case id closes all.
// Counts saturate. A front end accepts requests after the clearing pass and
// while the queue is not full, tracks the case id and places a classified
// command in a four-entry queue; a back end executes commands from the queue.
// A start event scans every activity slot of the open-count store: an empty
// slot is skipped; for an open one the pair counts are read, then written
// one pair at a time over the single write port of the pair-count memory,
// with one write only when the open slot is b itself. The open count of b is
// then read and written back. A complete or other event only changes the
// open flags; a read fetches the pair count, then loads the response register.
// After reset the pair-count memory is cleared one entry per cycle, over all
// 2^(2 * clog2(NUM_ACTIVITIES)) entries (4096 at the default size); req_ready
// stays low during that pass.
module parallel_activity_pair_counter_unit #(
   parameter int NUM_ACTIVITIES = papc_pkg::DEF_NUM_ACTIVITIES,
   parameter int COUNT_WIDTH    = papc_pkg::DEF_COUNT_WIDTH,
   parameter int OPEN_WIDTH     = papc_pkg::DEF_OPEN_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [papc_pkg::CASE_W-1:0]       req_case_id,
   input  logic [papc_pkg::ACT_W-1:0]        req_activity,
   input  logic [papc_pkg::LC_W-1:0]         req_lifecycle,
   input  logic [papc_pkg::ACT_W-1:0]        req_other_activity,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [papc_pkg::PAIR_COUNT_W-1:0] rsp_pair_count
);
   import papc_pkg::*;

   // Front end to queue.
   logic           push;
   papc_cmd_type   push_cmd;

   // Queue to back end.
   papc_cmd_type   q_data;
   papc_qstat_type q_stat;
   logic           q_pop;

   // High once the pair-count memory has been cleared after reset.
   logic           init_done;

   papc_front #(
      .NUM_ACTIVITIES (NUM_ACTIVITIES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_case_id        (req_case_id),
      .req_activity       (req_activity),
      .req_lifecycle      (req_lifecycle),
      .req_other_activity (req_other_activity),
      .q_stat             (q_stat),
      .init_done          (init_done),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   papc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .q_data   (q_data),
      .q_stat   (q_stat)
   );

   papc_back #(
      .NUM_ACTIVITIES (NUM_ACTIVITIES),
      .COUNT_WIDTH    (COUNT_WIDTH),
      .OPEN_WIDTH     (OPEN_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_stat         (q_stat),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .init_done      (init_done),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pair_count (rsp_pair_count)
   );

   // Reset starts the clearing pass, so no request is taken in the next cycle.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted right after reset");

   // A read leaves the queue only when the response register can take its result.
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_data.op == OP_READ) |-> (!rsp_valid || rsp_ready))
      else $error("read issued while response register is blocked");

   // A new response appears only after a read left the queue and passed through S_RDOUT into the response register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_pop && q_data.op == OP_READ, 2))
      else $error("response without a matching read");

   // The queue never takes a transfer while full, and never gives one while empty.
   assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full) && !(q_pop && q_stat.empty))
      else $error("command queue overrun or underrun");

endmodule
